@@ hw/rtl/binary_to_decimal_ascii_with_point_assert.svh @@
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_with_point_assert.svh
// Assertion macros shared by the formatter's checker.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_WITH_POINT_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_WITH_POINT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDAP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bdap: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BDAP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bdap: next-cycle check failed");

`endif

@@ hw/rtl/bdap_pkg.sv @@
// ----------------------------------------------------------------------------
// bdap_pkg
// Types and constants for the binary to decimal ASCII formatter.
// ----------------------------------------------------------------------------
package bdap_pkg;

    localparam int MAX_DIGITS = 8;
    localparam int VALUE_W    = 27;
    localparam int FRAC_W     = 4;
    localparam int CHAR_W     = 8;
    localparam int BCD_W      = 4 * MAX_DIGITS;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int SHIFT_W    = $clog2(VALUE_W);
    localparam int CMP_W      = (CNT_W > FRAC_W) ? CNT_W : FRAC_W;

    localparam longint unsigned SAT_LIMIT = longint'(10) ** MAX_DIGITS - 1;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [BCD_W-1:0]   t_bcd;
    typedef logic [CNT_W-1:0]   t_cnt;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_STRIP,
        S_EMIT
    } t_state;

endpackage

@@ hw/rtl/bdap_dabble.sv @@
// ----------------------------------------------------------------------------
// bdap_dabble
// Serial binary to BCD converter, shift-and-add-3, one input bit per cycle.
// ----------------------------------------------------------------------------
module bdap_dabble (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  bdap_pkg::t_value i_value,
    output logic            o_done,
    output bdap_pkg::t_bcd  o_bcd
);
    import bdap_pkg::*;

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [SHIFT_W-1:0]  r_cnt, n_cnt;
    t_value              r_bin, n_bin;
    t_bcd                r_bcd, n_bcd;
    t_bcd                bcd_adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            bcd_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? r_bcd[4*d +: 4] + 4'd3
                                                          : r_bcd[4*d +: 4];
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_bcd  = '0;
            n_bin  = (64'(i_value) > SAT_LIMIT) ? VALUE_W'(SAT_LIMIT) : i_value;
        end else if (r_busy) begin
            n_bcd = {bcd_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
            n_bin = {r_bin[VALUE_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == SHIFT_W'(VALUE_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

@@ hw/rtl/binary_to_decimal_ascii_with_point.sv @@
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_with_point
// Formats an unsigned value as ASCII decimal text with an optional point.
// ----------------------------------------------------------------------------
// One input beat carries a value (saturated at 99999999) and a fraction digit
// count. The value runs through a bit-serial shift-and-add-3 converter, one
// bit per cycle; leading zero digits are then dropped one per cycle (up to
// 7); then one character leaves per cycle while i_ready is high, through the
// output register, digits most significant first with a '.' before the last
// fraction-count digits (clamped to the digits printed), and o_last_char
// marks the final one. o_ready is high only while no item is in work, but it
// rises as soon as the last character is loaded, while that character may
// still wait at the output.
module binary_to_decimal_ascii_with_point (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [bdap_pkg::VALUE_W-1:0] i_value,
    input  logic [bdap_pkg::FRAC_W-1:0]  i_frac_digits,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [bdap_pkg::CHAR_W-1:0]  o_ascii_char,
    output logic                         o_last_char
);
    import bdap_pkg::*;

    t_state              r_state, n_state;
    t_bcd                r_digits, n_digits;
    t_cnt                r_left, n_left;
    t_cnt                r_point, n_point;
    logic                r_point_pend, n_point_pend;
    logic [FRAC_W-1:0]   r_frac_in, n_frac_in;
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_out_char, n_out_char;
    logic                r_out_last, n_out_last;

    logic                conv_start;
    logic                conv_done;
    t_bcd                conv_bcd;
    logic [3:0]          top_digit;
    t_cnt                frac_clamp;

    bdap_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (conv_start),
        .i_value (i_value),
        .o_done  (conv_done),
        .o_bcd   (conv_bcd)
    );

    assign top_digit  = r_digits[BCD_W-1 -: 4];
    assign frac_clamp = (CMP_W'(r_frac_in) > CMP_W'(r_left)) ? r_left : CNT_W'(r_frac_in);

    always_comb begin
        n_state      = r_state;
        n_digits     = r_digits;
        n_left       = r_left;
        n_point      = r_point;
        n_point_pend = r_point_pend;
        n_frac_in    = r_frac_in;
        n_out_valid  = r_out_valid;
        n_out_char   = r_out_char;
        n_out_last   = r_out_last;
        conv_start   = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_frac_in  = i_frac_digits;
                    conv_start = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                if (conv_done) begin
                    n_digits = conv_bcd;
                    n_left   = CNT_W'(MAX_DIGITS);
                    n_state  = S_STRIP;
                end
            end
            S_STRIP: begin
                // keep at least one digit so zero prints as '0'
                if (top_digit == 4'd0 && r_left > CNT_W'(1)) begin
                    n_digits = {r_digits[BCD_W-5:0], 4'd0};
                    n_left   = r_left - 1'b1;
                end else begin
                    n_point      = frac_clamp;
                    n_point_pend = (frac_clamp != '0);
                    n_state      = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    if (r_point_pend && r_left == r_point) begin
                        n_out_char   = CHAR_POINT;
                        n_out_last   = 1'b0;
                        n_point_pend = 1'b0;
                    end else begin
                        n_out_char = CHAR_ZERO + {4'd0, top_digit};
                        n_out_last = (r_left == CNT_W'(1));
                        n_digits   = {r_digits[BCD_W-5:0], 4'd0};
                        n_left     = r_left - 1'b1;
                        if (r_left == CNT_W'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_point_pend <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_point_pend <= n_point_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digits   <= n_digits;
        r_left     <= n_left;
        r_point    <= n_point;
        r_frac_in  <= n_frac_in;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_ascii_char = r_out_char;
    assign o_last_char  = r_out_last;

endmodule

@@ hw/rtl/bdap_checker.sv @@
// ----------------------------------------------------------------------------
// bdap_checker
// Port-level assertions for the formatter, bound to the top level.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_with_point_assert.svh"

module bdap_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic [bdap_pkg::VALUE_W-1:0] i_value,
    input logic [bdap_pkg::FRAC_W-1:0]  i_frac_digits,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [bdap_pkg::CHAR_W-1:0]  o_ascii_char,
    input logic                         o_last_char
);
    import bdap_pkg::*;

    logic                        out_hold;
    logic                        in_hold;
    logic                        char_ok;
    logic [CHAR_W:0]             out_beat;
    logic [VALUE_W+FRAC_W-1:0]   in_beat;

    assign out_hold = o_valid && !i_ready;
    assign in_hold  = i_valid && !o_ready;
    assign char_ok  = (o_ascii_char == CHAR_POINT) ||
                      ((o_ascii_char >= CHAR_ZERO) && (o_ascii_char <= CHAR_ZERO + 8'd9));
    assign out_beat = {o_ascii_char, o_last_char};
    assign in_beat  = {i_value, i_frac_digits};

    // a stalled output beat keeps its payload
    `BDAP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_hold, o_valid && $stable(out_beat))
    // a waiting input beat keeps its payload
    `BDAP_ASSERT_NXT(a_in_hold, i_clk, i_rst_n, in_hold, i_valid && $stable(in_beat))
    // only digits and the point ever leave
    `BDAP_ASSERT_IMP(a_char_set, i_clk, i_rst_n, o_valid, char_ok)
    // the point is never the final character
    `BDAP_ASSERT_IMP(a_point_not_last, i_clk, i_rst_n, o_valid && o_ascii_char == CHAR_POINT, !o_last_char)
    // an accepted item keeps the block busy in the next cycle
    `BDAP_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

endmodule

bind binary_to_decimal_ascii_with_point bdap_checker u_bdap_checker (.*);
